// ===== rtl/kmst_pkg.sv =====
// Package with the beat types and fixed constants of the spanning-tree edge filter.
package kmst_pkg;

	localparam int NODE_W   = 6;
	localparam int WEIGHT_W = 16;
	localparam int COUNT_W  = 7;
	localparam int RANK_W   = 3;

	// Only nodes below this limit can ever be named by an edge.
	localparam int NODE_SPAN = 1 << NODE_W;

	localparam logic [RANK_W-1:0]  RANK_MAX         = 3'd7;
	localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

	typedef struct packed {
		logic                first_edge;
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
		logic [WEIGHT_W-1:0] weight;
	} edge_t;

	typedef struct packed {
		logic                accepted;
		logic [NODE_W-1:0]   edge_a;
		logic [NODE_W-1:0]   edge_b;
		logic [WEIGHT_W-1:0] edge_weight;
		logic                tree_done;
	} result_t;

endpackage

// ===== rtl/kmst_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module kmst_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read share the one clock edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/kruskal_union_find_edge_filter.sv =====
// Top level of the spanning-tree edge filter: sequencer, forest store and result register.
//
// Edges arrive sorted by ascending weight, one per start beat while busy is low. The block keeps
// a disjoint-set forest (parent and rank per node) in one RAM and walks parent links through its
// registered read port, one link per cycle. An edge that is rejected at once (tree complete or
// endpoint outside the node count) is answered straight from idle. Otherwise an edge is accepted,
// the walk follows node_a and then node_b up to their roots, and, when the roots differ, the RAM
// takes a link write, followed by a rank raise write when equal ranks raise the new root's rank.
// The depth of any node is at most its root's rank; with 64 nodes one tree is at most six links
// deep and two separate trees have ranks that sum to at most ten. The result is registered on
// result and marked by strobe for exactly one cycle, in the cycle after the last cycle of work;
// the receiver cannot stall it. Clearing the forest on first_edge does not write the RAM: a valid
// bit per entry is dropped at once and an entry that is not valid reads as its own root with rank
// zero. node_count is written through the cfg channel while the block is idle.
module kruskal_union_find_edge_filter
	import kmst_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  edge_t               edge_item,
	output logic                strobe,
	output result_t             result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [COUNT_W-1:0]  cfg_data
);

	// Table depth, index width and the width used for count comparisons.
	localparam int DEPTH  = (MAX_NODES < NODE_SPAN) ? MAX_NODES : NODE_SPAN;
	localparam int IW     = $clog2(DEPTH);
	localparam int CW     = $clog2(MAX_NODES + 1);
	localparam int XW     = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
	localparam int WORD_W = RANK_W + IW;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WALK_A = 3'd1;
	localparam logic [2:0] ST_WALK_B = 3'd2;
	localparam logic [2:0] ST_JOIN   = 3'd3;
	localparam logic [2:0] ST_BUMP   = 3'd4;

	logic [2:0]         state_q, state_d;
	logic [COUNT_W-1:0] node_count_q;
	logic [COUNT_W-1:0] count_q;
	logic [DEPTH-1:0]   valid_q;
	edge_t              edge_q;
	logic [IW-1:0]      cur_q, cur_d;
	logic [IW-1:0]      ra_q;
	logic [RANK_W-1:0]  rank_a_q;
	logic [IW-1:0]      child_q;
	logic [RANK_W-1:0]  child_rank_q;
	logic [IW-1:0]      root_q;
	logic [RANK_W-1:0]  root_rank_q;
	logic               strobe_q;
	result_t            result_q;

	logic               accept;
	logic [XW-1:0]      n_eff;
	logic [XW-1:0]      target;
	logic [XW-1:0]      count_eff;
	logic               eligible;
	logic               done_now;

	logic               we;
	logic [IW-1:0]      waddr;
	logic [WORD_W-1:0]  wdata;
	logic [WORD_W-1:0]  rdata;
	logic [IW-1:0]      par;
	logic [RANK_W-1:0]  rk;
	logic               at_root;
	logic [RANK_W-1:0]  bumped_rank;

	logic               emit;
	logic               emit_acc;
	logic               emit_done;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = start && !busy;
	assign strobe    = strobe_q;
	assign result    = result_q;

	// Node count in effect, clamped to the range the forest supports.
	always_comb begin
		if (XW'(node_count_q) < XW'(2)) begin
			n_eff = XW'(2);
		end else if (XW'(node_count_q) > XW'(MAX_NODES)) begin
			n_eff = XW'(MAX_NODES);
		end else begin
			n_eff = XW'(node_count_q);
		end
	end

	assign target    = n_eff - XW'(1);
	assign count_eff = edge_item.first_edge ? '0 : XW'(count_q);
	assign done_now  = (count_eff >= target);
	assign eligible  = !done_now && (XW'(edge_item.node_a) < n_eff)
		&& (XW'(edge_item.node_b) < n_eff);

	// Forest store: each word holds a rank above a parent link.
	kmst_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_forest (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (cur_d),
		.rdata (rdata)
	);

	// An entry that was not written since the last clear is its own root with rank zero.
	assign par     = valid_q[cur_q] ? rdata[IW-1:0] : cur_q;
	assign rk      = valid_q[cur_q] ? rdata[WORD_W-1:IW] : '0;
	assign at_root = (par == cur_q);

	assign bumped_rank = (root_rank_q == RANK_MAX) ? root_rank_q : root_rank_q + RANK_W'(1);

	// Merge writes: hang the child under the new root, then raise the root's rank if needed.
	always_comb begin
		we    = (state_q == ST_JOIN) || (state_q == ST_BUMP);
		waddr = (state_q == ST_JOIN) ? child_q : root_q;
		wdata = (state_q == ST_JOIN) ? {child_rank_q, root_q} : {bumped_rank, root_q};
	end

	// Sequencer: next state, next read address and the result to emit.
	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		emit      = 1'b0;
		emit_acc  = 1'b0;
		emit_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (eligible) begin
						cur_d   = IW'(edge_item.node_a);
						state_d = ST_WALK_A;
					end else begin
						emit      = 1'b1;
						emit_done = done_now;
					end
				end
			end
			ST_WALK_A: begin
				if (at_root) begin
					cur_d   = IW'(edge_q.node_b);
					state_d = ST_WALK_B;
				end else begin
					cur_d = par;
				end
			end
			ST_WALK_B: begin
				if (at_root) begin
					if (cur_q == ra_q) begin
						emit      = 1'b1;
						emit_done = (XW'(count_q) >= target);
						state_d   = ST_IDLE;
					end else begin
						state_d = ST_JOIN;
					end
				end else begin
					cur_d = par;
				end
			end
			ST_JOIN: begin
				if (child_rank_q == root_rank_q) begin
					state_d = ST_BUMP;
				end else begin
					emit      = 1'b1;
					emit_acc  = 1'b1;
					emit_done = (XW'(count_q) + XW'(1) >= target);
					state_d   = ST_IDLE;
				end
			end
			ST_BUMP: begin
				emit      = 1'b1;
				emit_acc  = 1'b1;
				emit_done = (XW'(count_q) + XW'(1) >= target);
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state: sequencer, count, valid bits, node count and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			valid_q      <= '0;
			node_count_q <= NODE_COUNT_RESET;
			strobe_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (accept && edge_item.first_edge) begin
				valid_q <= '0;
				count_q <= '0;
			end else begin
				if (we) begin
					valid_q[waddr] <= 1'b1;
				end
				if (emit_acc) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end
		end
	end

	// Payload registers: the edge, the walk pointer, the roots found and the result beat.
	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (accept) begin
			edge_q <= edge_item;
		end
		if ((state_q == ST_WALK_A) && at_root) begin
			ra_q     <= cur_q;
			rank_a_q <= rk;
		end
		// The lower-ranked root becomes the child; on a tie the second root does.
		if ((state_q == ST_WALK_B) && at_root) begin
			if (rank_a_q < rk) begin
				child_q      <= ra_q;
				child_rank_q <= rank_a_q;
				root_q       <= cur_q;
				root_rank_q  <= rk;
			end else begin
				child_q      <= cur_q;
				child_rank_q <= rk;
				root_q       <= ra_q;
				root_rank_q  <= rank_a_q;
			end
		end
		if (emit) begin
			result_q.accepted    <= emit_acc;
			result_q.edge_a      <= (state_q == ST_IDLE) ? edge_item.node_a : edge_q.node_a;
			result_q.edge_b      <= (state_q == ST_IDLE) ? edge_item.node_b : edge_q.node_b;
			result_q.edge_weight <= (state_q == ST_IDLE) ? edge_item.weight : edge_q.weight;
			result_q.tree_done   <= emit_done;
		end
	end

	// A result beat is only ever shown while the sequencer is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result beat shown while busy");

	// Every accepted edge adds exactly one to the accepted count.
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.accepted |-> count_q == $past(count_q) + COUNT_W'(1))
		else $error("accepted count out of step with accepted edges");

	// A merge never hangs a root under itself.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_JOIN) |-> (child_q != root_q))
		else $error("merge of a root with itself");

	// The rank raise only follows the link write of the same merge.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUMP) |-> ($past(state_q) == ST_JOIN))
		else $error("rank raise without a link write");

endmodule
